### hdl/lln_pkg.sv
// Shared types and character constants for the log line number extractor.
package lln_pkg;

	// Characters that the scanner recognizes.
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_PAREN = 8'h28;

	// Scan phase, one-hot coded.
	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_FIRST  = 4'b0010,
		PH_SEP    = 4'b0100,
		PH_SECOND = 4'b1000
	} lln_phase_t;

	// Control handed from the scanner to the list stage with each byte.
	typedef struct packed {
		logic close_num;
		logic last;
	} lln_ctl_t;

endpackage

### hdl/lln_scan.sv
// Byte scanner: tracks the digit/separator/digit pattern and accumulates the line number.
module lln_scan #(
	parameter int NUMBER_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic [7:0]             char_code,
	input  logic                   last_of_log,
	output lln_pkg::lln_ctl_t      ctl,
	output logic [NUMBER_BITS-1:0] cand
);

	lln_pkg::lln_phase_t phase_q, phase_next;
	logic [NUMBER_BITS-1:0] acc_q, acc_after, acc_next;
	logic [NUMBER_BITS+3:0] acc_ext, acc_times_ten;
	logic                   is_digit, is_sep, close_num;
	logic [3:0]             digit;

	// Character classes.
	assign is_digit = (char_code >= lln_pkg::CHAR_ZERO) && (char_code <= lln_pkg::CHAR_NINE);
	assign is_sep   = (char_code == lln_pkg::CHAR_COLON) || (char_code == lln_pkg::CHAR_PAREN);
	assign digit    = is_digit ? 4'(char_code - lln_pkg::CHAR_ZERO) : 4'd0;

	// Times ten plus digit as shifts and adds; the top four bits flag an overflow.
	assign acc_ext       = {4'd0, acc_q};
	assign acc_times_ten = (acc_ext << 3) + (acc_ext << 1) + (NUMBER_BITS+4)'(digit);

	// Phase transitions and the accumulator update.
	always_comb begin
		phase_next = lln_pkg::PH_IDLE;
		acc_after  = acc_q;
		close_num  = 1'b0;
		unique case (phase_q)
			lln_pkg::PH_IDLE: begin
				phase_next = is_digit ? lln_pkg::PH_FIRST : lln_pkg::PH_IDLE;
			end
			lln_pkg::PH_FIRST: begin
				if (is_digit) begin
					phase_next = lln_pkg::PH_FIRST;
				end else if (is_sep) begin
					phase_next = lln_pkg::PH_SEP;
				end
			end
			lln_pkg::PH_SEP: begin
				if (is_digit) begin
					phase_next = lln_pkg::PH_SECOND;
					acc_after  = NUMBER_BITS'(digit);
				end
			end
			lln_pkg::PH_SECOND: begin
				if (is_digit) begin
					phase_next = lln_pkg::PH_SECOND;
					if (acc_times_ten[NUMBER_BITS+3:NUMBER_BITS] != 4'd0) begin
						acc_after = '1;
					end else begin
						acc_after = acc_times_ten[NUMBER_BITS-1:0];
					end
				end else begin
					close_num = 1'b1;
				end
			end
			default: begin
				phase_next = lln_pkg::PH_IDLE;
			end
		endcase
		// The last byte closes a number that is still open.
		if (last_of_log && phase_next == lln_pkg::PH_SECOND) begin
			close_num = 1'b1;
		end
		acc_next = (close_num || last_of_log) ? '0 : acc_after;
	end

	assign cand          = acc_after;
	assign ctl.close_num = close_num;
	assign ctl.last      = last_of_log;

	// Scanner state; the last byte returns it to idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lln_pkg::PH_IDLE;
			acc_q   <= '0;
		end else if (advance) begin
			phase_q <= last_of_log ? lln_pkg::PH_IDLE : phase_next;
			acc_q   <= acc_next;
		end
	end

endmodule

### hdl/lln_cell.sv
// One list cell: holds a recorded line number, compares it with the candidate, shifts on insert.
module lln_cell #(
	parameter int NUMBER_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   shift_en,
	input  logic                   clear,
	input  logic                   prev_valid,
	input  logic [NUMBER_BITS-1:0] prev_value,
	input  logic [NUMBER_BITS-1:0] cand,
	output logic                   valid,
	output logic [NUMBER_BITS-1:0] value,
	output logic                   match
);

	logic                   valid_q;
	logic [NUMBER_BITS-1:0] value_q;

	// Occupancy flag; cleared at the end of each log.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= prev_valid;
		end
	end

	// Stored value takes the neighbor's value on insert.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			value_q <= prev_value;
		end
	end

	assign valid = valid_q;
	assign value = value_q;
	assign match = valid_q && (value_q == cand);

endmodule

### hdl/log_line_number_extractor_unit.sv
// Log line number extractor: takes one log byte per transfer and reports each new line number
// found after a "digits:" or "digits(" prefix, plus a summary result on the last byte of a log.
// Throughput is one byte per cycle while results are taken; a byte passes a scanner stage and
// then a list stage, and its result is held in an output register. The list is a chain of
// LIST_DEPTH cells that all compare the candidate at once and shift by one on each insert.
// Numbers saturate at 2^NUMBER_BITS - 1, and line_number shows the low 32 bits.
module log_line_number_extractor_unit #(
	parameter int LIST_DEPTH  = 10,
	parameter int NUMBER_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  char_code,
	input  logic        last_of_log,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [31:0] line_number,
	output logic        line_valid,
	output logic [3:0]  lines_found,
	output logic        log_done
);

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);

	lln_pkg::lln_ctl_t      scan_ctl, ctl_s1;
	logic [NUMBER_BITS-1:0] scan_cand, cand_s1;
	logic                   valid_s1;
	logic                   item_xfer, out_free, process, record, full, any_match, emit;
	logic [CNT_W-1:0]       cnt_q, cnt_after;
	logic [LIST_DEPTH-1:0]  cell_valid, cell_match;
	logic [NUMBER_BITS-1:0] cell_value [LIST_DEPTH];
	logic                   out_valid_q, line_valid_q, log_done_q;
	logic [31:0]            line_number_q;
	logic [3:0]             lines_found_q;

	// Handshake: the output register frees up when empty or when its result is taken.
	assign out_free   = !out_valid_q || result_ready;
	assign item_ready = !valid_s1 || out_free;
	assign item_xfer  = item_valid && item_ready;
	assign process    = valid_s1 && out_free;

	// Scanner stage.
	lln_scan #(.NUMBER_BITS(NUMBER_BITS)) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (item_xfer),
		.char_code  (char_code),
		.last_of_log(last_of_log),
		.ctl        (scan_ctl),
		.cand       (scan_cand)
	);

	// Register between scanner and list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			ctl_s1  <= scan_ctl;
			cand_s1 <= scan_cand;
		end
	end

	// Chain of list cells; cell zero takes the new number.
	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		lln_cell #(.NUMBER_BITS(NUMBER_BITS)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (record),
			.clear     (process && ctl_s1.last),
			.prev_valid((i == 0) ? 1'b1 : cell_valid[(i == 0) ? 0 : i-1]),
			.prev_value((i == 0) ? cand_s1 : cell_value[(i == 0) ? 0 : i-1]),
			.cand      (cand_s1),
			.valid     (cell_valid[i]),
			.value     (cell_value[i]),
			.match     (cell_match[i])
		);
	end

	// Record decision: nonzero, not yet listed, room left.
	assign any_match = |cell_match;
	assign full      = (cnt_q == CNT_W'(LIST_DEPTH));
	assign record    = process && ctl_s1.close_num && (cand_s1 != '0) && !full && !any_match;
	assign cnt_after = record ? cnt_q + CNT_W'(1) : cnt_q;
	assign emit      = process && (record || ctl_s1.last);

	// Entry count, cleared by the last byte of a log.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (process) begin
			cnt_q <= ctl_s1.last ? '0 : cnt_after;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			line_number_q <= record ? 32'(cand_s1) : 32'd0;
			line_valid_q  <= record;
			lines_found_q <= 4'(cnt_after);
			log_done_q    <= ctl_s1.last;
		end
	end

	assign result_valid = out_valid_q;
	assign line_number  = line_number_q;
	assign line_valid   = line_valid_q;
	assign lines_found  = lines_found_q;
	assign log_done     = log_done_q;

endmodule

### hdl/lln_checker.sv
// Port-level checks for the log line number extractor, bound to the top level.
module lln_checker #(
	parameter int LIST_DEPTH = 10
) (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic [31:0] line_number,
	input logic        line_valid,
	input logic [3:0]  lines_found,
	input logic        log_done
);

	// A waiting result keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(line_number)
			&& $stable(line_valid) && $stable(lines_found) && $stable(log_done))
		else $error("result changed while stalled");

	// Every result carries a new line or ends a log.
	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> line_valid || log_done)
		else $error("result with neither a line nor end of log");

	// The count never exceeds the list size.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (LIST_DEPTH > 15) || (lines_found <= 4'(LIST_DEPTH)))
		else $error("lines_found beyond list size");

	// A newly recorded line cannot leave the count at zero.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && line_valid |-> (LIST_DEPTH > 15) || (lines_found != 4'd0))
		else $error("line recorded with zero count");

endmodule

bind log_line_number_extractor_unit lln_checker #(.LIST_DEPTH(LIST_DEPTH)) u_lln_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.line_number (line_number),
	.line_valid  (line_valid),
	.lines_found (lines_found),
	.log_done    (log_done)
);
